@@ rtl/core/checked_integer_alu_assert.svh @@
// Assertion macros for the checked integer ALU checker.
`ifndef CHECKED_INTEGER_ALU_ASSERT_SVH
`define CHECKED_INTEGER_ALU_ASSERT_SVH

// Checked on every clock edge outside reset.
`define CIA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("checked_integer_alu: assertion failed");

// Checked on every clock edge, reset included.
`define CIA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("checked_integer_alu: assertion failed");

`endif

@@ rtl/core/cia_pkg.sv @@
// Types, codes and constants of the checked integer ALU.
package cia_pkg;

  localparam int SDataW     = 128;
  localparam int SUserW     = 5;
  localparam int MDataW     = 64;
  localparam int MUserW     = 1;
  localparam int QueueDepth = 2;
  localparam int MulSteps   = 4;
  localparam int DivSteps   = 64;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_REM = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    TYP_S32 = 2'd0,
    TYP_S64 = 2'd1,
    TYP_U32 = 2'd2,
    TYP_BAD = 2'd3
  } typ_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } st_e;

  // Classified operation handed from front to back.
  typedef struct packed {
    act_e        act;
    logic        bad;    // result is 0 / not ok, no arithmetic needed
    logic        sgn;
    logic        w32;
    logic        neg;    // sign of product or quotient
    logic        a_neg;  // sign of remainder
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] lim;    // largest product magnitude allowed
  } fe_t;

endpackage

@@ rtl/core/cia_front.sv @@
// Front end: unpacks a beat, extends operands and flags trivial failures.
module cia_front (
  input  logic [cia_pkg::SDataW-1:0] s_data_i,
  input  logic [cia_pkg::SUserW-1:0] s_user_i,
  output cia_pkg::fe_t               fe_o
);

  logic [2:0]  act_raw;
  logic [1:0]  typ_raw;
  logic [63:0] a_raw, b_raw, a_ext, b_ext, min_v;
  logic        sgn, w32, is_dr, b_zero;

  assign act_raw = s_user_i[2:0];
  assign typ_raw = s_user_i[4:3];
  assign a_raw   = s_data_i[63:0];
  assign b_raw   = s_data_i[127:64];

  always_comb begin
    sgn = 1'b1;
    w32 = 1'b1;
    case (cia_pkg::typ_e'(typ_raw))
      cia_pkg::TYP_S32: begin
        a_ext = {{32{a_raw[31]}}, a_raw[31:0]};
        b_ext = {{32{b_raw[31]}}, b_raw[31:0]};
      end
      cia_pkg::TYP_S64: begin
        a_ext = a_raw;
        b_ext = b_raw;
        w32   = 1'b0;
      end
      default: begin
        a_ext = {32'd0, a_raw[31:0]};
        b_ext = {32'd0, b_raw[31:0]};
        sgn   = 1'b0;
      end
    endcase
  end

  assign min_v  = w32 ? {{33{1'b1}}, 31'd0} : {1'b1, 63'd0};
  assign is_dr  = (act_raw == cia_pkg::ACT_DIV) || (act_raw == cia_pkg::ACT_REM);
  assign b_zero = (b_ext == 64'd0);

  always_comb begin
    fe_o.act   = cia_pkg::act_e'(act_raw);
    fe_o.sgn   = sgn;
    fe_o.w32   = w32;
    fe_o.a     = a_ext;
    fe_o.b     = b_ext;
    fe_o.a_neg = sgn & a_ext[63];
    fe_o.neg   = sgn & (a_ext[63] ^ b_ext[63]);
    fe_o.ma    = fe_o.a_neg ? (64'd0 - a_ext) : a_ext;
    fe_o.mb    = (sgn & b_ext[63]) ? (64'd0 - b_ext) : b_ext;
    if (!sgn) begin
      fe_o.lim = {32'd0, 32'hFFFF_FFFF};
    end else if (w32) begin
      fe_o.lim = fe_o.neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    end else begin
      fe_o.lim = fe_o.neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    fe_o.bad = (typ_raw == cia_pkg::TYP_BAD) || (act_raw > cia_pkg::ACT_REM)
            || (is_dr && b_zero)
            || ((act_raw == cia_pkg::ACT_DIV) && sgn && (a_ext == min_v)
                && (b_ext == {64{1'b1}}));
  end

endmodule

@@ rtl/core/cia_fifo.sv @@
// Short queue of classified operations between front and back.
module cia_fifo #(
  parameter int DEPTH = cia_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  cia_pkg::fe_t wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output cia_pkg::fe_t rdata_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cia_pkg::fe_t    mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= nxt(wptr_q);
      if (do_pop)  rptr_q <= nxt(rptr_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

endmodule

@@ rtl/core/cia_back.sv @@
// Back end: combinational add/sub, sequential multiply and divide, result register.
module cia_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       deq_valid_i,
  input  cia_pkg::fe_t               deq_data_i,
  output logic                       deq_pop_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [cia_pkg::MDataW-1:0] m_data_o,
  output logic [cia_pkg::MUserW-1:0] m_user_o
);

  cia_pkg::st_e  state_q, state_d;
  cia_pkg::fe_t  item_q, item_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [127:0]  acc_q, acc_d;
  logic [63:0]   pp_q, pp_d;
  logic [1:0]    sh_q, sh_d;
  logic [63:0]   dvd_q, dvd_d, rem_q, rem_d;
  logic          out_valid_q, out_valid_d, out_ok_q, out_ok_d;
  logic [63:0]   out_value_q, out_value_d;
  logic          out_free;

  // add / subtract straight from the queue head
  logic [63:0] as_s, as_x;
  logic        as_sub, as_ovf, as_ok;
  // finishing of multiply and divide
  logic [63:0] fin_mag, fin_val;
  logic        fin_neg, fin_ok;
  // divide step
  logic [64:0] trial;
  logic        ge;

  assign out_free = !out_valid_q || m_ready_i;

  always_comb begin
    as_sub = (deq_data_i.act == cia_pkg::ACT_SUB);
    as_s   = as_sub ? (deq_data_i.a - deq_data_i.b) : (deq_data_i.a + deq_data_i.b);
    as_x   = as_sub ? ((deq_data_i.a ^ deq_data_i.b) & (deq_data_i.a ^ as_s))
                    : ((deq_data_i.a ^ as_s) & (deq_data_i.b ^ as_s));
    as_ovf = as_x[63];
    if (deq_data_i.sgn) begin
      as_ok = !as_ovf && (!deq_data_i.w32 || (&as_s[63:31]) || !(|as_s[63:31]));
    end else begin
      as_ok = !(|as_s[63:32]);
    end
  end

  always_comb begin
    case (item_q.act)
      cia_pkg::ACT_MUL: begin
        fin_mag = acc_q[63:0];
        fin_neg = item_q.neg;
        fin_ok  = !(|acc_q[127:64]) && (acc_q[63:0] <= item_q.lim);
      end
      cia_pkg::ACT_DIV: begin
        fin_mag = dvd_q;
        fin_neg = item_q.neg;
        fin_ok  = 1'b1;
      end
      default: begin
        fin_mag = rem_q;
        fin_neg = item_q.a_neg;
        fin_ok  = 1'b1;
      end
    endcase
    fin_val = fin_neg ? (64'd0 - fin_mag) : fin_mag;
  end

  assign trial = {rem_q, dvd_q[63]};
  assign ge    = (trial >= {1'b0, item_q.mb});

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    pp_d        = pp_q;
    sh_d        = sh_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    deq_pop_o   = 1'b0;
    out_valid_d = out_valid_q && !m_ready_i;
    out_value_d = out_value_q;
    out_ok_d    = out_ok_q;
    case (state_q)
      cia_pkg::ST_IDLE: begin
        if (deq_valid_i) begin
          item_d = deq_data_i;
          cnt_d  = '0;
          if (deq_data_i.bad) begin
            if (out_free) begin
              deq_pop_o   = 1'b1;
              out_valid_d = 1'b1;
              out_value_d = '0;
              out_ok_d    = 1'b0;
            end
          end else begin
            case (deq_data_i.act)
              cia_pkg::ACT_ADD, cia_pkg::ACT_SUB: begin
                if (out_free) begin
                  deq_pop_o   = 1'b1;
                  out_valid_d = 1'b1;
                  out_value_d = as_ok ? as_s : 64'd0;
                  out_ok_d    = as_ok;
                end
              end
              cia_pkg::ACT_MUL: begin
                deq_pop_o = 1'b1;
                acc_d     = '0;
                state_d   = cia_pkg::ST_MUL;
              end
              default: begin
                deq_pop_o = 1'b1;
                rem_d     = '0;
                dvd_d     = deq_data_i.ma;
                state_d   = cia_pkg::ST_DIV;
              end
            endcase
          end
        end
      end
      cia_pkg::ST_MUL: begin
        // one 32x32 partial product per cycle, added in the cycle after
        pp_d = item_q.ma[cnt_q[1]*32 +: 32] * item_q.mb[cnt_q[0]*32 +: 32];
        sh_d = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
        if (cnt_q != '0) acc_d = acc_q + ({64'd0, pp_q} << {sh_q, 5'd0});
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(cia_pkg::MulSteps)) state_d = cia_pkg::ST_DONE;
      end
      cia_pkg::ST_DIV: begin
        rem_d = ge ? 64'(trial - {1'b0, item_q.mb}) : trial[63:0];
        dvd_d = {dvd_q[62:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(cia_pkg::DivSteps - 1)) state_d = cia_pkg::ST_DONE;
      end
      cia_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = fin_ok ? fin_val : 64'd0;
          out_ok_d    = fin_ok;
          state_d     = cia_pkg::ST_IDLE;
        end
      end
      default: state_d = cia_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cia_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    acc_q       <= acc_d;
    pp_q        <= pp_d;
    sh_q        <= sh_d;
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    out_value_q <= out_value_d;
    out_ok_q    <= out_ok_d;
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_value_q;
  assign m_user_o  = out_ok_q;

endmodule

@@ rtl/core/checked_integer_alu.sv @@
// Top level of the overflow-checked 32/64-bit integer ALU.
//
//  channel   | dir | tuser (low bit first)        | tdata (low bit first)
//  ----------+-----+------------------------------+---------------------------------
//  s_axis    | in  | action[2:0] type_sel[4:3]    | operand_a[63:0] operand_b[127:64]
//  m_axis    | out | ok[0]                        | value[63:0]
//
// Add and subtract are done in the back end's idle state, one beat per cycle while
// m_axis is ready. Multiply holds the back end for a dequeue, four 32x32 partial
// products on one multiplier, a last add and the result; divide and remainder for
// a dequeue, one restoring quotient bit per cycle and the result.
// Reset clears the queue, the sequencer and the output valid; no clearing pass.
// The result register lets the queue keep filling while m_axis stalls.
module checked_integer_alu #(
  parameter int QUEUE_DEPTH = cia_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // operand_a, operand_b
  input  logic [cia_pkg::SDataW-1:0] s_axis_tdata,
  // action, type_sel
  input  logic [cia_pkg::SUserW-1:0] s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // value
  output logic [cia_pkg::MDataW-1:0] m_axis_tdata,
  // ok
  output logic [cia_pkg::MUserW-1:0] m_axis_tuser
);

  cia_pkg::fe_t fe, head;
  logic         full, head_valid, pop;

  // classify the incoming beat
  cia_front u_front (
    .s_data_i (s_axis_tdata),
    .s_user_i (s_axis_tuser),
    .fe_o     (fe)
  );

  assign s_axis_tready = !full;

  // decouples classification from execution
  cia_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .wdata_i (fe),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (head)
  );

  // execute and hold the result until taken
  cia_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .deq_valid_i (head_valid),
    .deq_data_i  (head),
    .deq_pop_o   (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_user_o    (m_axis_tuser)
  );

endmodule

@@ rtl/core/cia_checker.sv @@
// Port-level checker for the checked integer ALU, bound to the top level.
`include "checked_integer_alu_assert.svh"

module cia_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [cia_pkg::MDataW-1:0] m_axis_tdata,
  input logic [cia_pkg::MUserW-1:0] m_axis_tuser
);

  // a failed operation always reports zero
  `CIA_ASSERT(a_fail_zero, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
  // a stalled beat holds
  `CIA_ASSERT(a_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata})))
  // nothing offered directly after reset is seen
  `CIA_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !m_axis_tvalid)

endmodule

bind checked_integer_alu cia_checker u_cia_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
